// ===== rtl/core/ppi_pkg.sv =====
package ppi_pkg;

	localparam int MAX_COLORS_DEF = 256;
	localparam int COLOR_W        = 24;
	localparam int OUT_IDX_W      = 9;
	localparam int OUT_CNT_W      = 9;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               occupied;
		logic               start_image;
	} pix_t;

endpackage

// ===== rtl/core/ppi_cell.sv =====
module ppi_cell #(
	parameter int IW       = 9,
	parameter int CELL_IDX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  ppi_pkg::pix_t   in_pix,
	input  logic            in_found,
	input  logic [IW-1:0]   in_idx,
	input  logic            in_added,
	input  logic [IW-1:0]   in_cnt,
	output logic            out_v,
	output ppi_pkg::pix_t   out_pix,
	output logic            out_found,
	output logic [IW-1:0]   out_idx,
	output logic            out_added,
	output logic [IW-1:0]   out_cnt
);
	import ppi_pkg::*;

	logic [COLOR_W-1:0] entry_q;
	logic               valid_q;
	logic               eff;
	logic               look;
	logic               hit;
	logic               fill;
	logic               valid_next;

	logic               v_q;
	pix_t               pix_q;
	logic               found_q;
	logic [IW-1:0]      idx_q;
	logic               added_q;
	logic [IW-1:0]      cnt_q;

	// start of image drops this entry before the pixel looks at it
	assign eff        = valid_q & ~in_pix.start_image;
	assign look       = in_v & in_pix.occupied & ~in_found;
	assign hit        = look & eff & (entry_q == in_pix.color);
	assign fill       = look & ~eff;
	assign valid_next = eff | fill;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			v_q     <= 1'b0;
		end else if (adv) begin
			v_q <= in_v;
			if (in_v) begin
				valid_q <= valid_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fill) begin
				entry_q <= in_pix.color;
			end
			pix_q   <= in_pix;
			found_q <= in_found | hit | fill;
			idx_q   <= (hit | fill) ? IW'(CELL_IDX) : in_idx;
			added_q <= in_added | fill;
			cnt_q   <= in_cnt + {{(IW-1){1'b0}}, valid_next};
		end
	end

	assign out_v     = v_q;
	assign out_pix   = pix_q;
	assign out_found = found_q;
	assign out_idx   = idx_q;
	assign out_added = added_q;
	assign out_cnt   = cnt_q;

endmodule

// ===== rtl/core/pixel_palette_indexer.sv =====
// Pixel palette indexer.
// Input channel pix_*: one RGB pixel per beat with occupied and start_image
// flags. Output channel res_*: one beat per pixel, in order, carrying the
// palette index (MAX_COLORS when transparent or when the palette is full),
// whether the pixel appended an entry, and the entry count after it.
// The palette lives in a row of MAX_COLORS cells, one entry each; a pixel
// moves one cell per cycle while the row is not frozen, so every pixel sees
// the entries written by the pixels ahead of it.
// Each accepted pixel passes through every cell before its result beat.
// Throughput: one pixel per cycle while res_stall does not freeze the row;
// the search never holds the row.
// Stall: while a result beat waits under res_stall, the whole row freezes
// and pix_stall is raised; nothing is lost.
// Reset: all cells come up empty, the palette count is zero and no result
// beat is pending. Entry contents are not cleared.
module pixel_palette_indexer #(
	parameter int MAX_COLORS = ppi_pkg::MAX_COLORS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_stall,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic                          occupied,
	input  logic                          start_image,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [ppi_pkg::OUT_IDX_W-1:0] color_index,
	output logic                          added,
	output logic [ppi_pkg::OUT_CNT_W-1:0] entries_used
);
	import ppi_pkg::*;

	localparam int IW = $clog2(MAX_COLORS + 1);

	logic          adv;
	logic          v_c     [0:MAX_COLORS];
	pix_t          pix_c   [0:MAX_COLORS];
	logic          found_c [0:MAX_COLORS];
	logic [IW-1:0] idx_c   [0:MAX_COLORS];
	logic          added_c [0:MAX_COLORS];
	logic [IW-1:0] cnt_c   [0:MAX_COLORS];

	assign adv       = ~(v_c[MAX_COLORS] & res_stall);
	assign pix_stall = ~adv;

	assign v_c[0]     = pix_valid;
	assign pix_c[0]   = '{color: {red, green, blue}, occupied: occupied,
	                      start_image: start_image};
	assign found_c[0] = 1'b0;
	assign idx_c[0]   = IW'(MAX_COLORS);
	assign added_c[0] = 1'b0;
	assign cnt_c[0]   = '0;

	for (genvar i = 0; i < MAX_COLORS; i++) begin : g_cell
		ppi_cell #(
			.IW       (IW),
			.CELL_IDX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_v      (v_c[i]),
			.in_pix    (pix_c[i]),
			.in_found  (found_c[i]),
			.in_idx    (idx_c[i]),
			.in_added  (added_c[i]),
			.in_cnt    (cnt_c[i]),
			.out_v     (v_c[i+1]),
			.out_pix   (pix_c[i+1]),
			.out_found (found_c[i+1]),
			.out_idx   (idx_c[i+1]),
			.out_added (added_c[i+1]),
			.out_cnt   (cnt_c[i+1])
		);
	end

	assign res_valid    = v_c[MAX_COLORS];
	assign color_index  = OUT_IDX_W'(idx_c[MAX_COLORS]);
	assign added        = added_c[MAX_COLORS];
	assign entries_used = OUT_CNT_W'(cnt_c[MAX_COLORS]);

endmodule
